### hdl/shtab_pkg.sv
// Shared types, constants and codes for the string key hash table.
// Used by every module of the block; depends on nothing else.
package shtab_pkg;

   localparam int MAX_SLOTS_DEF = 1024;
   localparam int MAX_KEY_BYTES = 64;
   localparam int VALUE_BITS = 20;
   localparam int HASH_W = 32;
   localparam logic [HASH_W-1:0] HASH_START = 32'd5381;
   localparam int CAP_W = 4;
   localparam logic [CAP_W-1:0] CAP_RESET = 4'd10;
   localparam logic [CAP_W-1:0] MIN_LOG2 = 4'd4;
   localparam int WORDS = (MAX_KEY_BYTES + 7) / 8;
   localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int STATUS_W = 3;
   localparam int SLOT_OUT_W = 10;

   localparam logic [1:0] CMD_PUT = 2'd0;
   localparam logic [1:0] CMD_GET = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT  = 3'd0,
      ST_MISS = 3'd1,
      ST_NEW  = 3'd2,
      ST_FULL = 3'd3,
      ST_LONG = 3'd4
   } shtab_status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_META,
      S_CHECK,
      S_KREAD,
      S_KCMP,
      S_STORE,
      S_CLEAR,
      S_DONE
   } shtab_state_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [VALUE_BITS-1:0] value;
      logic [HASH_W-1:0]     hash;
      logic [LEN_W-1:0]      len;
      logic                  overflow;
   } shtab_desc_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
      logic [2:0]        lane;
      logic [7:0]        data;
   } shtab_kwr_type;

   typedef struct packed {
      logic                  used;
      logic [LEN_W-1:0]      len;
      logic [VALUE_BITS-1:0] value;
   } shtab_meta_type;

endpackage

### hdl/string_key_hash_table.sv
// Top level of the string key hash table: capacity register and block wiring.
// Depends on shtab_pkg, shtab_front, shtab_queue and shtab_back.
// Throughput: one key byte per cycle while the queue is not full and no reset sweep runs;
// a last byte queues an operation for the probe sequencer, which walks the probed slots,
// compares key words one at a time and stores a new key word by word; a clear sweeps all slots.
// Reset: a sweep over all MAX_SLOTS slots empties the slot table; req_ready stays low during it.
module string_key_hash_table #(
   parameter int MAX_SLOTS = shtab_pkg::MAX_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [7:0]                          req_key_byte,
   input  logic                                req_key_last,
   input  logic [shtab_pkg::VALUE_BITS-1:0]    req_put_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [shtab_pkg::STATUS_W-1:0]      rsp_status,
   output logic [shtab_pkg::VALUE_BITS-1:0]    rsp_found_value,
   output logic [shtab_pkg::SLOT_OUT_W-1:0]    rsp_slot_index,
   input  logic                                csr_we,
   input  logic [shtab_pkg::CAP_W-1:0]         csr_wdata
);
   import shtab_pkg::*;

   localparam int SLOT_W = $clog2(MAX_SLOTS);

   logic [CAP_W-1:0] cap_log2_ff, cap_log2_in;
   logic [CAP_W-1:0] lg_lo, lg_eff;
   logic [SLOT_W:0]  cap;

   shtab_kwr_type  kwr;
   shtab_desc_type desc;
   shtab_desc_type head;
   logic           push;
   logic           pop;
   logic           q_full;
   logic           q_empty;
   logic           init_busy;
   logic [WORD_W-1:0] rd_word;
   logic [63:0]    rd_data;

   assign cap_log2_in = csr_we ? csr_wdata : cap_log2_ff;
   assign lg_lo = (cap_log2_ff < MIN_LOG2) ? MIN_LOG2 : cap_log2_ff;
   assign lg_eff = (32'(lg_lo) > SLOT_W) ? CAP_W'(SLOT_W) : lg_lo;
   assign cap = (SLOT_W + 1)'(1) << lg_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_log2_ff <= CAP_RESET;
      end else begin
         cap_log2_ff <= cap_log2_in;
      end
   end

   shtab_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_key_byte  (req_key_byte),
      .req_key_last  (req_key_last),
      .req_put_value (req_put_value),
      .q_full        (q_full),
      .init_busy     (init_busy),
      .kwr           (kwr),
      .push          (push),
      .desc          (desc)
   );

   shtab_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .kwr     (kwr),
      .push    (push),
      .desc_in (desc),
      .pop     (pop),
      .rd_word (rd_word),
      .rd_data (rd_data),
      .head    (head),
      .full    (q_full),
      .empty   (q_empty)
   );

   shtab_back #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cap             (cap),
      .head            (head),
      .q_empty         (q_empty),
      .pop             (pop),
      .rd_word         (rd_word),
      .rd_data         (rd_data),
      .init_busy       (init_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_slot_index  (rsp_slot_index)
   );

endmodule

### hdl/shtab_front.sv
// Front end: takes key bytes, folds the hash and tracks the key length.
// Depends on shtab_pkg; feeds shtab_queue with key bytes and descriptors.
module shtab_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_cmd,
   input  logic [7:0]                       req_key_byte,
   input  logic                             req_key_last,
   input  logic [shtab_pkg::VALUE_BITS-1:0] req_put_value,
   input  logic                             q_full,
   input  logic                             init_busy,
   output shtab_pkg::shtab_kwr_type         kwr,
   output logic                             push,
   output shtab_pkg::shtab_desc_type        desc
);
   import shtab_pkg::*;

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic              accept;
   logic              in_range;
   logic [HASH_W-1:0] hash_next;
   logic [LEN_W-1:0]  len_next;

   assign req_ready = !q_full && !init_busy;
   assign accept = req_valid && req_ready;
   assign in_range = len_ff < LEN_W'(MAX_KEY_BYTES);
   assign hash_next = (hash_ff << 5) + hash_ff + HASH_W'(req_key_byte);
   assign len_next = in_range ? len_ff + LEN_W'(1) : len_ff;

   assign kwr.valid = accept && in_range;
   assign kwr.word = WORD_W'(len_ff >> 3);
   assign kwr.lane = len_ff[2:0];
   assign kwr.data = req_key_byte;

   assign push = accept && req_key_last;
   assign desc.cmd = req_cmd;
   assign desc.value = req_put_value;
   assign desc.hash = hash_next;
   assign desc.len = len_next;
   assign desc.overflow = ovf_ff || !in_range;

   always_comb begin
      hash_in = hash_ff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_key_last) begin
            hash_in = HASH_START;
            len_in = '0;
            ovf_in = 1'b0;
         end else begin
            hash_in = hash_next;
            len_in = len_next;
            ovf_in = ovf_ff || !in_range;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_START;
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

### hdl/shtab_queue.sv
// Two-entry queue of operation descriptors, each with its own key word bank.
// Depends on shtab_pkg; written by shtab_front and drained by shtab_back.
module shtab_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  shtab_pkg::shtab_kwr_type            kwr,
   input  logic                                push,
   input  shtab_pkg::shtab_desc_type           desc_in,
   input  logic                                pop,
   input  logic [shtab_pkg::WORD_W-1:0]        rd_word,
   output logic [63:0]                         rd_data,
   output shtab_pkg::shtab_desc_type           head,
   output logic                                full,
   output logic                                empty
);
   import shtab_pkg::*;

   shtab_desc_type desc_ff [2];
   logic [63:0]    bank_ff [2][WORDS];
   logic           wp_ff, wp_in;
   logic           rp_ff, rp_in;
   logic [1:0]     count_ff, count_in;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head = desc_ff[rp_ff];
   assign rd_data = bank_ff[rp_ff][rd_word];

   always_comb begin
      wp_in = push ? !wp_ff : wp_ff;
      rp_in = pop ? !rp_ff : rp_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         desc_ff[wp_ff] <= desc_in;
      end
      if (kwr.valid) begin
         if (kwr.lane == 3'd0) begin
            bank_ff[wp_ff][kwr.word] <= {56'd0, kwr.data};
         end else begin
            bank_ff[wp_ff][kwr.word][{kwr.lane, 3'b000} +: 8] <= kwr.data;
         end
      end
   end

endmodule

### hdl/shtab_back.sv
// Back end: probe sequencer with the slot and key word memories and the result register.
// Depends on shtab_pkg; takes descriptors and key words from shtab_queue.
module shtab_back #(
   parameter int MAX_SLOTS = shtab_pkg::MAX_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(MAX_SLOTS):0]          cap,
   input  shtab_pkg::shtab_desc_type           head,
   input  logic                                q_empty,
   output logic                                pop,
   output logic [shtab_pkg::WORD_W-1:0]        rd_word,
   input  logic [63:0]                         rd_data,
   output logic                                init_busy,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [shtab_pkg::STATUS_W-1:0]      rsp_status,
   output logic [shtab_pkg::VALUE_BITS-1:0]    rsp_found_value,
   output logic [shtab_pkg::SLOT_OUT_W-1:0]    rsp_slot_index
);
   import shtab_pkg::*;

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int KADDR_W = $clog2(MAX_SLOTS * WORDS);

   shtab_meta_type meta_mem [MAX_SLOTS];
   logic [63:0]    key_mem [MAX_SLOTS * WORDS];
   shtab_meta_type meta_q;
   logic [63:0]    key_q;

   shtab_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SLOT_W:0]       probe_ff, probe_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [SLOT_W-1:0]     sweep_ff, sweep_in;
   shtab_status_type      status_ff, status_in;
   logic [VALUE_BITS-1:0] found_ff, found_in;
   logic [SLOT_W-1:0]     where_ff, where_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   shtab_status_type      rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_found_ff;
   logic [SLOT_W-1:0]     rsp_where_ff;

   logic [SLOT_W-1:0]     mask;
   logic                  is_put;
   logic [LEN_W:0]        nwords;
   logic [WORD_W-1:0]     last_word;
   logic                  sweep_end;
   logic                  probe_end;
   logic                  load;
   logic                  meta_we;
   logic [SLOT_W-1:0]     meta_waddr;
   shtab_meta_type        meta_wdata;
   logic                  key_we;
   logic [KADDR_W-1:0]    kaddr;
   logic                  key_eq;
   logic                  len_eq;

   assign mask = SLOT_W'(cap - (SLOT_W + 1)'(1));
   assign is_put = head.cmd == CMD_PUT;
   assign nwords = ((LEN_W + 1)'(head.len) + (LEN_W + 1)'(7)) >> 3;
   assign last_word = WORD_W'(nwords - (LEN_W + 1)'(1));
   assign sweep_end = sweep_ff == SLOT_W'(MAX_SLOTS - 1);
   assign probe_end = probe_ff + (SLOT_W + 1)'(1) == cap;
   assign load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign kaddr = KADDR_W'(slot_ff) * KADDR_W'(WORDS) + KADDR_W'(word_ff);
   assign key_eq = key_q == rd_data;
   assign len_eq = meta_q.len == head.len;

   assign pop = load;
   assign rd_word = word_ff;
   assign init_busy = state_ff == S_INIT;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_slot_index = SLOT_OUT_W'(rsp_where_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (sweep_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               if (head.cmd == CMD_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (head.overflow) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_META;
               end
            end
         end
         S_META: state_in = S_CHECK;
         S_CHECK: begin
            if (!meta_q.used) begin
               state_in = (is_put && nwords != '0) ? S_STORE : S_DONE;
            end else if (!len_eq) begin
               state_in = probe_end ? S_DONE : S_META;
            end else if (nwords == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_KREAD;
            end
         end
         S_KREAD: state_in = S_KCMP;
         S_KCMP: begin
            if (!key_eq) begin
               state_in = probe_end ? S_DONE : S_META;
            end else if (word_ff == last_word) begin
               state_in = S_DONE;
            end else begin
               state_in = S_KREAD;
            end
         end
         S_STORE: begin
            if (word_ff == last_word) begin
               state_in = S_DONE;
            end
         end
         S_CLEAR: begin
            if (sweep_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      slot_in = slot_ff;
      probe_in = probe_ff;
      word_in = word_ff;
      sweep_in = sweep_ff;
      status_in = status_ff;
      found_in = found_ff;
      where_in = where_ff;
      meta_we = 1'b0;
      meta_waddr = slot_ff;
      meta_wdata = '{used: 1'b1, len: head.len, value: head.value};
      key_we = 1'b0;
      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            meta_we = 1'b1;
            meta_waddr = sweep_ff;
            meta_wdata = '0;
            sweep_in = sweep_end ? '0 : sweep_ff + SLOT_W'(1);
            status_in = ST_HIT;
            found_in = '0;
            where_in = '0;
         end
         S_IDLE: begin
            slot_in = SLOT_W'(head.hash) & mask;
            probe_in = '0;
            word_in = '0;
            found_in = '0;
            where_in = '0;
            if (head.overflow) begin
               status_in = ST_LONG;
            end else begin
               status_in = is_put ? ST_FULL : ST_MISS;
            end
         end
         S_CHECK: begin
            word_in = '0;
            if (!meta_q.used) begin
               if (is_put) begin
                  meta_we = 1'b1;
                  status_in = ST_NEW;
                  where_in = slot_ff;
               end
            end else if (!len_eq) begin
               slot_in = (slot_ff + SLOT_W'(1)) & mask;
               probe_in = probe_ff + (SLOT_W + 1)'(1);
            end else if (nwords == '0) begin
               meta_we = is_put;
               found_in = is_put ? '0 : meta_q.value;
               status_in = ST_HIT;
               where_in = slot_ff;
            end
         end
         S_KCMP: begin
            if (!key_eq) begin
               slot_in = (slot_ff + SLOT_W'(1)) & mask;
               probe_in = probe_ff + (SLOT_W + 1)'(1);
            end else if (word_ff == last_word) begin
               meta_we = is_put;
               found_in = is_put ? '0 : meta_q.value;
               status_in = ST_HIT;
               where_in = slot_ff;
            end else begin
               word_in = word_ff + WORD_W'(1);
            end
         end
         S_STORE: begin
            key_we = 1'b1;
            word_in = word_ff + WORD_W'(1);
         end
         S_META, S_KREAD, S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      probe_ff <= probe_in;
      word_ff <= word_in;
      status_ff <= status_in;
      found_ff <= found_in;
      where_ff <= where_in;
      if (load) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff <= found_ff;
         rsp_where_ff <= where_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_q <= meta_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[kaddr] <= rd_data;
      end
      key_q <= key_mem[kaddr];
   end

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_META) |-> (probe_ff < cap))
      else $error("probe walk ran past the slots in use");

   a_store_put: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE) |-> (is_put && !q_empty))
      else $error("key store without a pending put");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the finishing state");

endmodule
